[hw/rtl/twmm_pkg.sv]
// ----------------------------------------------------------------------------
// twmm_pkg
// Shared types and constants of the ternary-weight matrix multiply engine.
// ----------------------------------------------------------------------------
package twmm_pkg;

  localparam int IDX_W   = 6;
  localparam int DATA_W  = 8;
  localparam int RES_W   = 15;
  localparam int OP_W    = 2;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 7;
  localparam int ROWS_W  = 5;
  localparam int COLS_W  = 5;
  localparam int INNER_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_W  = 2'd0,
    OP_LOAD_A  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_e;

  localparam logic [CFG_IW-1:0] CFG_ROWS  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_COLS  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_INNER = 2'd2;

  localparam logic [ROWS_W-1:0]  ROWS_RST  = 5'd16;
  localparam logic [COLS_W-1:0]  COLS_RST  = 5'd16;
  localparam logic [INNER_W-1:0] INNER_RST = 7'd64;

  localparam logic [1:0] W_ZERO  = 2'b00;
  localparam logic [1:0] W_PLUS  = 2'b01;
  localparam logic [1:0] W_MINUS = 2'b11;

  typedef struct packed {
    logic wr_w;
    logic wr_a;
    logic load_req;
    logic step;
  } twmm_cmd_t;

  typedef struct packed {
    logic load_w_ok;
    logic load_a_ok;
    logic compute_ok;
    logic step_ok;
  } twmm_status_t;

endpackage

[hw/rtl/twmm_ctrl.sv]
// ----------------------------------------------------------------------------
// twmm_ctrl
// Request sequencer: issues store writes and walks the inner loop of a
// compute request.
// ----------------------------------------------------------------------------
module twmm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  twmm_pkg::twmm_status_t status_i,
  output twmm_pkg::twmm_cmd_t    cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);
  import twmm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;
  logic   done_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          cmd_o.wr_w     = status_i.load_w_ok;
          cmd_o.wr_a     = status_i.load_a_ok;
          cmd_o.load_req = status_i.compute_ok;
        end
      end
      ST_RUN: begin
        cmd_o.step = status_i.step_ok;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept_i && status_i.compute_ok) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (!status_i.step_ok) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

[hw/rtl/twmm_datapath.sv]
// ----------------------------------------------------------------------------
// twmm_datapath
// Configuration registers, weight and activation stores, range checks and
// the ternary accumulator.
// ----------------------------------------------------------------------------
module twmm_datapath #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 16,
  parameter int MAX_INNER = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_write_i,
  input  logic [twmm_pkg::CFG_IW-1:0]     cfg_index_i,
  input  logic [twmm_pkg::CFG_DW-1:0]     cfg_data_i,
  input  logic [twmm_pkg::OP_W-1:0]       op_i,
  input  logic [twmm_pkg::IDX_W-1:0]      row_index_i,
  input  logic [twmm_pkg::IDX_W-1:0]      col_index_i,
  input  logic signed [twmm_pkg::DATA_W-1:0] value_i,
  input  twmm_pkg::twmm_cmd_t             cmd_i,
  output twmm_pkg::twmm_status_t          status_o,
  output logic signed [twmm_pkg::RES_W-1:0] dot_result_o
);
  import twmm_pkg::*;

  localparam int W_DEPTH = MAX_ROWS * MAX_INNER;
  localparam int A_DEPTH = MAX_INNER * MAX_COLS;
  localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;

  logic [ROWS_W-1:0]  row_count_q;
  logic [COLS_W-1:0]  col_count_q;
  logic [INNER_W-1:0] inner_count_q;

  logic [IDX_W-1:0]   r_q;
  logic [IDX_W-1:0]   c_q;
  logic [INNER_W-1:0] t_q;
  logic               rd_valid_q;

  logic [1:0]              wmem [W_DEPTH];
  logic [DATA_W-1:0]       amem [A_DEPTH];
  logic [1:0]              w_rd_q;
  logic signed [DATA_W-1:0] a_rd_q;
  logic signed [RES_W-1:0] acc_q;
  logic signed [RES_W-1:0] acc_d;
  logic signed [RES_W-1:0] a_ext;

  logic            row_in_w, col_in_inner, row_in_inner, col_in_a, col_in_cols, row_in_rows;
  logic [1:0]      w_code;
  logic [W_AW-1:0] w_wr_addr, w_rd_addr;
  logic [A_AW-1:0] a_wr_addr, a_rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q   <= ROWS_RST;
      col_count_q   <= COLS_RST;
      inner_count_q <= INNER_RST;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        CFG_ROWS:  row_count_q   <= cfg_data_i[ROWS_W-1:0];
        CFG_COLS:  col_count_q   <= cfg_data_i[COLS_W-1:0];
        CFG_INNER: inner_count_q <= cfg_data_i[INNER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign row_in_rows  = (int'(row_index_i) < int'(row_count_q)) &&
                        (int'(row_index_i) < MAX_ROWS);
  assign col_in_inner = (int'(col_index_i) < int'(inner_count_q)) &&
                        (int'(col_index_i) < MAX_INNER);
  assign row_in_inner = (int'(row_index_i) < int'(inner_count_q)) &&
                        (int'(row_index_i) < MAX_INNER);
  assign col_in_cols  = (int'(col_index_i) < int'(col_count_q)) &&
                        (int'(col_index_i) < MAX_COLS);
  assign row_in_w     = row_in_rows && col_in_inner;
  assign col_in_a     = row_in_inner && col_in_cols;

  assign status_o.load_w_ok  = (op_i == OP_LOAD_W) && row_in_w;
  assign status_o.load_a_ok  = (op_i == OP_LOAD_A) && col_in_a;
  assign status_o.compute_ok = (op_i == OP_COMPUTE) && row_in_rows && col_in_cols;
  assign status_o.step_ok    = (int'(t_q) < int'(inner_count_q)) && (int'(t_q) < MAX_INNER);

  always_comb begin
    if (value_i == 8'sd1) begin
      w_code = W_PLUS;
    end else if (value_i == -8'sd1) begin
      w_code = W_MINUS;
    end else begin
      w_code = W_ZERO;
    end
  end

  assign w_wr_addr = W_AW'(int'(row_index_i) * MAX_INNER + int'(col_index_i));
  assign a_wr_addr = A_AW'(int'(row_index_i) * MAX_COLS + int'(col_index_i));
  assign w_rd_addr = W_AW'(int'(r_q) * MAX_INNER + int'(t_q));
  assign a_rd_addr = A_AW'(int'(t_q) * MAX_COLS + int'(c_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_w) begin
      wmem[w_wr_addr] <= w_code;
    end
    w_rd_q <= wmem[w_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      amem[a_wr_addr] <= value_i;
    end
    a_rd_q <= amem[a_rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q        <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.step;
      if (cmd_i.load_req) begin
        t_q <= '0;
      end else if (cmd_i.step) begin
        t_q <= t_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      r_q <= row_index_i;
      c_q <= col_index_i;
    end
  end

  assign a_ext = RES_W'(a_rd_q);

  always_comb begin
    acc_d = acc_q;
    if (rd_valid_q) begin
      case (w_rd_q)
        W_PLUS:  acc_d = acc_q + a_ext;
        W_MINUS: acc_d = acc_q - a_ext;
        default: acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign dot_result_o = acc_q;

endmodule

[hw/rtl/ternary_weight_matrix_multiply.sv]
// ----------------------------------------------------------------------------
// ternary_weight_matrix_multiply
// Ternary-weight matrix multiply engine with weight and activation stores.
//
//   channel   handshake               payload
//   request   start & !busy           op_i, row_index_i, col_index_i, value_i
//   result    dot_valid_o (1 cycle)   dot_result_o
//   config    cfg_valid_i & cfg_ready_o  cfg_index_i, cfg_data_i
//
// Loads finish when accepted; busy never rises for them.
// A compute request keeps busy high while it walks its inner loop of
// min(inner_count, MAX_INNER) terms, reading one weight/activation pair per
// cycle from the single read port of each store; the result strobes in the
// cycle after busy falls, when a new request may already start.
// Reset clears the sequencer and sets the configuration to its defaults; the
// stores are not cleared. The result channel cannot stall.
// ----------------------------------------------------------------------------
module ternary_weight_matrix_multiply #(
  parameter int MAX_ROWS  = 16,
  parameter int MAX_COLS  = 16,
  parameter int MAX_INNER = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [twmm_pkg::OP_W-1:0]          op_i,
  input  logic [twmm_pkg::IDX_W-1:0]         row_index_i,
  input  logic [twmm_pkg::IDX_W-1:0]         col_index_i,
  input  logic signed [twmm_pkg::DATA_W-1:0] value_i,
  output logic signed [twmm_pkg::RES_W-1:0]  dot_result_o,
  output logic                               dot_valid_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [twmm_pkg::CFG_IW-1:0]        cfg_index_i,
  input  logic [twmm_pkg::CFG_DW-1:0]        cfg_data_i
);
  import twmm_pkg::*;

  twmm_cmd_t    cmd;
  twmm_status_t status;
  logic         accept;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  twmm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (dot_valid_o)
  );

  twmm_datapath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .MAX_INNER (MAX_INNER)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_write_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .op_i         (op_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .dot_result_o (dot_result_o)
  );

endmodule

[hw/rtl/twmm_checker.sv]
// ----------------------------------------------------------------------------
// twmm_checker
// Port-level checks of the matrix multiply engine, bound to the top level.
// ----------------------------------------------------------------------------
module twmm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [twmm_pkg::OP_W-1:0]   op_i,
  input logic                        dot_valid_o
);
  import twmm_pkg::*;

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dot_valid_o |-> $past(busy))
    else $error("result without a preceding compute");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dot_valid_o |-> !busy)
    else $error("result shown while busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dot_valid_o |=> !dot_valid_o)
    else $error("result strobe longer than one cycle");

  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i != OP_COMPUTE)) |=> (!busy && !dot_valid_o))
    else $error("non-compute request made the block busy or gave a result");

endmodule

bind ternary_weight_matrix_multiply twmm_checker u_twmm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .op_i        (op_i),
  .dot_valid_o (dot_valid_o)
);
